// ----- rtl/mvd_pkg.sv -----
package mvd_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int DIGIT_W     = 4;
   localparam int BEAT_IDX_W  = $clog2(DIGIT_COUNT);

   // request codes
   localparam logic REQ_DISPLAY = 1'b0;
   localparam logic REQ_FAULT   = 1'b1;

   // result kinds
   localparam logic KIND_WRITE   = 1'b0;
   localparam logic KIND_RECOVER = 1'b1;

   // result status
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   localparam logic [15:0] MV_LIMIT       = 16'd5000;
   localparam logic [7:0]  DP_BIT         = 8'h80;
   localparam logic [2:0]  REG_RECOVER    = 3'd0;
   localparam logic [7:0]  DATA_RECOVER   = 8'h00;

   // reciprocal constants, exact for readings up to MV_LIMIT
   localparam logic [15:0] RECIP_10   = 16'd52429;   // 2^19 / 10, rounded up
   localparam logic [15:0] RECIP_100  = 16'd41944;   // 2^22 / 100, rounded up
   localparam logic [14:0] RECIP_1000 = 15'd16778;   // 2^24 / 1000, rounded up

   typedef struct packed {
      logic        req_type;
      logic [15:0] millivolts;
      logic        clear_stuck;
   } mvd_req_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] target_address;
      logic [2:0] reg_addr;
      logic [7:0] write_data;
      logic       status;
      logic       last;
   } mvd_rsp_type;

   typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] mvd_digits_type;

endpackage

// ----- rtl/mvd_digits.sv -----
module mvd_digits
   import mvd_pkg::*;
(
   input  logic [15:0]    millivolts,
   output mvd_digits_type digits
);

   logic [12:0] mv_clamped;
   logic [28:0] prod_10;
   logic [28:0] prod_100;
   logic [27:0] prod_1000;
   logic [9:0]  q10;
   logic [6:0]  q100;
   logic [3:0]  q1000;
   logic [12:0] units_rem;
   logic [9:0]  tens_rem;
   logic [6:0]  hund_rem;

   assign mv_clamped = (millivolts > MV_LIMIT) ? MV_LIMIT[12:0] : millivolts[12:0];

   assign prod_10   = 29'(mv_clamped) * 29'(RECIP_10);
   assign prod_100  = 29'(mv_clamped) * 29'(RECIP_100);
   assign prod_1000 = 28'(mv_clamped) * 28'(RECIP_1000);

   assign q10   = prod_10[28:19];
   assign q100  = prod_100[28:22];
   assign q1000 = prod_1000[27:24];

   // remainder against the next coarser quotient gives each digit
   assign units_rem = mv_clamped - 13'((13'(q10) << 3) + (13'(q10) << 1));
   assign tens_rem  = q10 - 10'((10'(q100) << 3) + (10'(q100) << 1));
   assign hund_rem  = q100 - 7'((7'(q1000) << 3) + (7'(q1000) << 1));

   assign digits[0] = units_rem[DIGIT_W-1:0];
   assign digits[1] = tens_rem[DIGIT_W-1:0];
   assign digits[2] = hund_rem[DIGIT_W-1:0];
   assign digits[3] = q1000;

endmodule

// ----- rtl/millivolt_display_write_sequencer.sv -----
// An accepted display request is loaded into the sequencer registers; each write
// beat then goes to the output register, one beat per cycle while rsp_stall is low.
// A recovery command takes the same path as a single beat. A new request is taken
// as the final beat is sent; fault requests only set the bus-stuck mark.
// Reset (synchronous, active high) clears the bus-stuck mark, the device address
// and all valid flags.
module millivolt_display_write_sequencer
   import mvd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  mvd_req_type req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output mvd_rsp_type rsp_data,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_wdata
);

   logic [6:0]            dev_addr_ff;
   logic                  stuck_ff, stuck_in;
   logic                  seq_valid_ff, seq_valid_in;
   logic                  seq_recover_ff, seq_recover_in;
   logic [BEAT_IDX_W-1:0] seq_cnt_ff, seq_cnt_in;
   mvd_digits_type        digits_ff, digits_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mvd_rsp_type           rsp_ff, rsp_in;

   mvd_digits_type        new_digits;
   mvd_rsp_type           beat;
   logic                  stuck_eff;
   logic                  req_fire;
   logic                  out_adv;
   logic                  emit;
   logic                  beat_last;

   mvd_digits u_digits (
      .millivolts (req_data.millivolts),
      .digits     (new_digits)
   );

   assign csr_ready = 1'b1;

   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign emit      = seq_valid_ff && out_adv;
   assign beat_last = seq_recover_ff || (seq_cnt_ff == BEAT_IDX_W'(DIGIT_COUNT - 1));

   // take a new request when the sequencer is empty or sends its final beat now
   assign req_stall = seq_valid_ff && !(emit && beat_last);
   assign req_fire  = req_valid && !req_stall;
   assign stuck_eff = req_data.clear_stuck ? 1'b0 : stuck_ff;

   always_comb begin
      beat = '0;
      beat.target_address = dev_addr_ff;
      beat.last           = beat_last;
      if (seq_recover_ff) begin
         beat.kind       = KIND_RECOVER;
         beat.reg_addr   = REG_RECOVER;
         beat.write_data = DATA_RECOVER;
         beat.status     = STATUS_ERROR;
      end else begin
         beat.kind       = KIND_WRITE;
         beat.reg_addr   = 3'(seq_cnt_ff) + 3'd1;
         beat.write_data = 8'(digits_ff[seq_cnt_ff]);
         if (seq_cnt_ff == BEAT_IDX_W'(DIGIT_COUNT - 1)) begin
            beat.write_data = beat.write_data | DP_BIT;
         end
         beat.status     = STATUS_OK;
      end
   end

   always_comb begin
      stuck_in       = stuck_ff;
      seq_valid_in   = seq_valid_ff;
      seq_recover_in = seq_recover_ff;
      seq_cnt_in     = seq_cnt_ff;
      digits_in      = digits_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      if (emit) begin
         if (beat_last) begin
            seq_valid_in = 1'b0;
         end else begin
            seq_cnt_in = seq_cnt_ff + BEAT_IDX_W'(1);
         end
      end

      if (req_fire) begin
         if (req_data.req_type == REQ_FAULT) begin
            stuck_in = 1'b1;
         end else begin
            stuck_in       = 1'b0;
            seq_valid_in   = 1'b1;
            seq_recover_in = stuck_eff;
            seq_cnt_in     = '0;
            digits_in      = new_digits;
         end
      end

      if (out_adv) begin
         rsp_valid_in = emit;
         rsp_in       = beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= '0;
         stuck_ff     <= 1'b0;
         seq_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            dev_addr_ff <= csr_wdata;
         end
         stuck_ff     <= stuck_in;
         seq_valid_ff <= seq_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_recover_ff <= seq_recover_in;
      seq_cnt_ff     <= seq_cnt_in;
      digits_ff      <= digits_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
